/* design/ptdp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the point/triangle depth pick block.
// No dependencies; every other design file imports this package.
package ptdp_pkg;

  localparam int CoordW   = 32;
  localparam int EdgeW    = CoordW + 1;   // vertex difference
  localparam int PointW   = CoordW + 2;   // query minus vertex minus offset
  localparam int MinDetW  = 62;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = MinDetW;
  localparam int MulW     = 35;           // signed multiplier operand width
  localparam int ProdW    = 2 * MulW;
  localparam int CrossW   = 69;           // det, a, b incl. sign flip headroom
  localparam int MagW     = 68;
  localparam int SplitW   = 34;           // low slice of a, b for the multiplier
  localparam int NumW     = 104;
  localparam int QuoW     = 34;           // quotient bits produced by the divider

  localparam logic [CfgIdxW-1:0] REG_QUERY_H  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_QUERY_V  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_H = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_V = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_DET  = 3'd4;

  typedef struct packed {
    logic signed [EdgeW-1:0]  e1h;
    logic signed [EdgeW-1:0]  e1v;
    logic signed [EdgeW-1:0]  e2h;
    logic signed [EdgeW-1:0]  e2v;
    logic signed [PointW-1:0] ph;
    logic signed [PointW-1:0] pv;
    logic signed [EdgeW-1:0]  dd0;
    logic signed [EdgeW-1:0]  dd1;
    logic signed [CoordW-1:0] v2d;
    logic                     last;
  } task_t;

endpackage

/* design/ptdp_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers and per-triangle vertex differences.
// Depends on ptdp_pkg.
module ptdp_front import ptdp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic signed [CoordW-1:0]   v0_h_i,
  input  logic signed [CoordW-1:0]   v0_v_i,
  input  logic signed [CoordW-1:0]   v0_d_i,
  input  logic signed [CoordW-1:0]   v1_h_i,
  input  logic signed [CoordW-1:0]   v1_v_i,
  input  logic signed [CoordW-1:0]   v1_d_i,
  input  logic signed [CoordW-1:0]   v2_h_i,
  input  logic signed [CoordW-1:0]   v2_v_i,
  input  logic signed [CoordW-1:0]   v2_d_i,
  input  logic                       last_tri_i,
  output task_t                      task_o,
  output logic [MinDetW-1:0]         min_det_o
);

  logic signed [CoordW-1:0] query_h_q, query_v_q, offset_h_q, offset_v_q;
  logic [MinDetW-1:0]       min_det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_h_q  <= '0;
      query_v_q  <= '0;
      offset_h_q <= '0;
      offset_v_q <= '0;
      min_det_q  <= MinDetW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QUERY_H:  query_h_q  <= cfg_data_i[CoordW-1:0];
        REG_QUERY_V:  query_v_q  <= cfg_data_i[CoordW-1:0];
        REG_OFFSET_H: offset_h_q <= cfg_data_i[CoordW-1:0];
        REG_OFFSET_V: offset_v_q <= cfg_data_i[CoordW-1:0];
        REG_MIN_DET:  min_det_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic signed [EdgeW-1:0] diff(logic signed [CoordW-1:0] x,
                                                   logic signed [CoordW-1:0] y);
    return EdgeW'(x) - EdgeW'(y);
  endfunction

  always_comb begin
    task_o.e1h  = diff(v0_h_i, v2_h_i);
    task_o.e1v  = diff(v0_v_i, v2_v_i);
    task_o.e2h  = diff(v1_h_i, v2_h_i);
    task_o.e2v  = diff(v1_v_i, v2_v_i);
    task_o.ph   = PointW'(query_h_q) - PointW'(v2_h_i) - PointW'(offset_h_q);
    task_o.pv   = PointW'(query_v_q) - PointW'(v2_v_i) - PointW'(offset_v_q);
    task_o.dd0  = diff(v0_d_i, v2_d_i);
    task_o.dd1  = diff(v1_d_i, v2_d_i);
    task_o.v2d  = v2_d_i;
    task_o.last = last_tri_i;
  end

  assign min_det_o = min_det_q;

endmodule

/* design/ptdp_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of prepared triangles between the front and back ends.
// Depends on ptdp_pkg.
module ptdp_queue import ptdp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output task_t data_o
);

  task_t      ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

endmodule

/* design/ptdp_back.sv */
`timescale 1ns / 1ps
// Back end: shared multiplier sequence, inside test, bit-serial divider,
// depth tracking and the result register. Depends on ptdp_pkg.
module ptdp_back import ptdp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  task_t                     q_data_i,
  output logic                      q_pop_o,
  input  logic [MinDetW-1:0]        min_det_i,
  output logic                      res_valid_o,
  input  logic                      res_pop_i,
  output logic                      hit_o,
  output logic signed [CoordW-1:0]  depth_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_TEST  = 3'd2;
  localparam logic [2:0] ST_NUM   = 3'd3;
  localparam logic [2:0] ST_DINIT = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [5:0] cnt_q, cnt_d;

  task_t                     task_q;
  logic signed [ProdW-1:0]   prod_q, acc_q;
  logic signed [CrossW-1:0]  det_q, a_q, b_q;
  logic [MagW-1:0]           mag_q, rem_q;
  logic signed [NumW-1:0]    num_q;
  logic [SplitW-1:0]         nsh_q;
  logic [QuoW-1:0]           quo_q;
  logic                      nneg_q, tri_hit_q;
  logic                      any_hit_q;
  logic signed [CoordW-1:0]  best_q;
  logic                      res_valid_q, res_hit_q;
  logic signed [CoordW-1:0]  res_depth_q;

  logic signed [MulW-1:0]    ma, mb;

  // Operand selection for the single shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == ST_PROD) begin
      unique case (step_q)
        3'd0:    begin ma = MulW'(task_q.e1h); mb = MulW'(task_q.e2v); end
        3'd1:    begin ma = MulW'(task_q.e1v); mb = MulW'(task_q.e2h); end
        3'd2:    begin ma = MulW'(task_q.ph);  mb = MulW'(task_q.e2v); end
        3'd3:    begin ma = MulW'(task_q.pv);  mb = MulW'(task_q.e2h); end
        3'd4:    begin ma = MulW'(task_q.e1h); mb = MulW'(task_q.pv);  end
        3'd5:    begin ma = MulW'(task_q.e1v); mb = MulW'(task_q.ph);  end
        default: ;
      endcase
    end else if (state_q == ST_NUM) begin
      unique case (step_q)
        3'd0:    begin ma = MulW'(task_q.dd0); mb = MulW'({1'b0, a_q[SplitW-1:0]}); end
        3'd1:    begin ma = MulW'(task_q.dd0);
                       mb = MulW'({2'b00, a_q[MagW-2:SplitW]}); end
        3'd2:    begin ma = MulW'(task_q.dd1); mb = MulW'({1'b0, b_q[SplitW-1:0]}); end
        3'd3:    begin ma = MulW'(task_q.dd1);
                       mb = MulW'({2'b00, b_q[MagW-2:SplitW]}); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  // Inside test on the signs of det, a and b.
  logic                     det_neg;
  logic signed [CrossW-1:0] det_abs, a_f, b_f;
  logic [CrossW:0]          ab_sum;
  logic                     in_tri;
  always_comb begin
    det_neg = det_q[CrossW-1];
    det_abs = det_neg ? -det_q : det_q;
    a_f     = det_neg ? -a_q : a_q;
    b_f     = det_neg ? -b_q : b_q;
    ab_sum  = {1'b0, a_f} + {1'b0, b_f};
    in_tri  = (det_q != '0) &&
              (det_abs[MagW-1:0] >= MagW'(min_det_i)) &&
              !a_f[CrossW-1] && !b_f[CrossW-1] &&
              (ab_sum <= (CrossW+1)'(det_abs[MagW-1:0]));
  end

  // Divider step: restoring, one quotient bit per cycle.
  logic [MagW:0] r2;
  logic          r_ge;
  assign r2   = {rem_q, nsh_q[SplitW-1]};
  assign r_ge = r2 >= {1'b0, mag_q};

  // Final depth: floor correction, offset by v2 depth, saturation.
  logic [QuoW:0]            q_abs;
  logic signed [QuoW+1:0]   q_s;
  logic signed [QuoW+2:0]   d_full;
  logic signed [CoordW-1:0] d_sat;
  logic                     take;
  logic                     any_hit_n;
  logic signed [CoordW-1:0] best_n;
  always_comb begin
    q_abs  = (QuoW+1)'(quo_q) + (QuoW+1)'(nneg_q && (rem_q != '0));
    q_s    = nneg_q ? -$signed({1'b0, q_abs}) : $signed({1'b0, q_abs});
    d_full = (QuoW+3)'(task_q.v2d) + (QuoW+3)'(q_s);
    if (d_full > (QuoW+3)'(signed'({1'b0, {(CoordW-1){1'b1}}}))) begin
      d_sat = {1'b0, {(CoordW-1){1'b1}}};
    end else if (d_full < -(QuoW+3)'(signed'({1'b0, 1'b1, {(CoordW-1){1'b0}}}))) begin
      d_sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      d_sat = d_full[CoordW-1:0];
    end
    take      = tri_hit_q && (!any_hit_q || (d_sat > best_q));
    any_hit_n = any_hit_q || tri_hit_q;
    best_n    = take ? d_sat : best_q;
  end

  logic res_free, done_go;
  assign res_free = !res_valid_q || res_pop_i;
  assign done_go  = (state_q == ST_DONE) && (!task_q.last || res_free);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE:  if (!q_empty_i) begin state_d = ST_PROD; step_d = '0; end
      ST_PROD:  begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) state_d = ST_TEST;
      end
      ST_TEST:  begin state_d = in_tri ? ST_NUM : ST_DONE; step_d = '0; end
      ST_NUM:   begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) state_d = ST_DINIT;
      end
      ST_DINIT: begin state_d = ST_DIV; cnt_d = '0; end
      ST_DIV:   begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(QuoW - 1)) state_d = ST_DONE;
      end
      ST_DONE:  if (done_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      any_hit_q   <= 1'b0;
      best_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      if (done_go && task_q.last) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      if (done_go) begin
        if (task_q.last) begin
          any_hit_q <= 1'b0;
          best_q    <= '0;
        end else begin
          any_hit_q <= any_hit_n;
          best_q    <= best_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) task_q <= q_data_i;
    if (done_go && task_q.last) begin
      res_hit_q   <= any_hit_n;
      res_depth_q <= any_hit_n ? best_n : '0;
    end
    unique case (state_q)
      ST_PROD: begin
        unique case (step_q)
          3'd1, 3'd3, 3'd5: acc_q <= prod_q;
          3'd2:             det_q <= CrossW'(acc_q - prod_q);
          3'd4:             a_q   <= CrossW'(acc_q - prod_q);
          3'd6:             b_q   <= CrossW'(acc_q - prod_q);
          default: ;
        endcase
      end
      ST_TEST: begin
        a_q       <= a_f;
        b_q       <= b_f;
        mag_q     <= det_abs[MagW-1:0];
        tri_hit_q <= in_tri;
      end
      ST_NUM: begin
        unique case (step_q)
          3'd1:       num_q <= NumW'(prod_q);
          3'd2, 3'd4: num_q <= num_q + (NumW'(prod_q) <<< SplitW);
          3'd3:       num_q <= num_q + NumW'(prod_q);
          default: ;
        endcase
      end
      ST_DINIT: begin
        nneg_q <= num_q[NumW-1];
        rem_q  <= num_q[NumW-1] ? MagW'((-num_q) >>> SplitW) : MagW'(num_q >>> SplitW);
        nsh_q  <= num_q[NumW-1] ? SplitW'(-num_q) : num_q[SplitW-1:0];
        quo_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= r_ge ? MagW'(r2 - {1'b0, mag_q}) : MagW'(r2);
        nsh_q <= {nsh_q[SplitW-2:0], 1'b0};
        quo_q <= {quo_q[QuoW-2:0], r_ge};
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign hit_o       = res_hit_q;
  assign depth_o     = res_depth_q;

endmodule

/* design/point_triangle_depth_pick_core.sv */
`timescale 1ns / 1ps
// Point/triangle depth pick: top level joining front end, queue and back end.
// Depends on ptdp_pkg, ptdp_front, ptdp_queue and ptdp_back.
//
// Tests the configured query point against a stream of triangles and, on the
// triangle flagged last, delivers whether any triangle held the point and the
// greatest interpolated depth. A triangle that is degenerate or misses ends
// in the back end after the inside test; a hit's time there is set by the shared
// 35x35 multiplier (10 products per hit) and the one-bit-per-cycle divider
// (34 quotient bits). Two prepared triangles can wait in the queue, and one
// result waits in the output register while work continues.
module point_triangle_depth_pick_core import ptdp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic signed [CoordW-1:0]  v0_h_i,
  input  logic signed [CoordW-1:0]  v0_v_i,
  input  logic signed [CoordW-1:0]  v0_d_i,
  input  logic signed [CoordW-1:0]  v1_h_i,
  input  logic signed [CoordW-1:0]  v1_v_i,
  input  logic signed [CoordW-1:0]  v1_d_i,
  input  logic signed [CoordW-1:0]  v2_h_i,
  input  logic signed [CoordW-1:0]  v2_v_i,
  input  logic signed [CoordW-1:0]  v2_d_i,
  input  logic                      last_tri_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      hit_o,
  output logic signed [CoordW-1:0]  depth_o
);

  task_t              fr_task, q_task;
  logic [MinDetW-1:0] min_det;
  logic               q_empty, q_pop, res_valid;

  ptdp_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .v0_h_i, .v0_v_i, .v0_d_i, .v1_h_i, .v1_v_i, .v1_d_i,
    .v2_h_i, .v2_v_i, .v2_d_i, .last_tri_i,
    .task_o    (fr_task),
    .min_det_o (min_det)
  );

  ptdp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (fr_task),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_task)
  );

  ptdp_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i   (q_empty),
    .q_data_i    (q_task),
    .q_pop_o     (q_pop),
    .min_det_i   (min_det),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .hit_o,
    .depth_o
  );

  assign empty = !res_valid;

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && q_empty)) else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("back end took from an empty queue");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_o) && $stable(depth_o)))
    else $error("waiting result changed before it was taken");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (depth_o == '0))
    else $error("result without a hit carries a nonzero depth");

endmodule

/* tb/sv/tb_point_triangle_depth_pick_core.sv */
`timescale 1ns / 1ps
// Testbench for point_triangle_depth_pick_core: directed table, then random meshes
// under several query/offset/min_det settings, checked against a local predictor.
// Depends on ptdp_pkg and the design files of the block.
module tb_point_triangle_depth_pick_core;
  import ptdp_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] v0h, v0v, v0d, v1h, v1v, v1d, v2h, v2v, v2d;
    logic last;
  } tri_t;

  typedef struct packed {
    logic hit;
    logic signed [CoordW-1:0] depth;
  } pick_t;

  typedef struct {
    tri_t  t;
    logic  typed;
    pick_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  tri_t drv = '0;
  logic empty;
  logic pop = 1'b0;
  logic hit_o;
  logic signed [CoordW-1:0] depth_o;

  point_triangle_depth_pick_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full,
    .v0_h_i(drv.v0h), .v0_v_i(drv.v0v), .v0_d_i(drv.v0d),
    .v1_h_i(drv.v1h), .v1_v_i(drv.v1v), .v1_d_i(drv.v1d),
    .v2_h_i(drv.v2h), .v2_v_i(drv.v2v), .v2_d_i(drv.v2d),
    .last_tri_i(drv.last),
    .empty, .pop, .hit_o, .depth_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the configuration and the running mesh state.
  logic signed [CoordW-1:0] q_h = '0, q_v = '0, off_h = '0, off_v = '0;
  logic [MinDetW-1:0] min_area = 62'd1;
  logic mesh_hit = 1'b0;
  logic signed [CoordW-1:0] mesh_best = '0;

  pick_t picks_due[$];
  row_t steps[$];
  int mismatches = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  // Folds one triangle into the mesh state; returns 1 when a pick result is due.
  function automatic logic pick_step(input tri_t t, output pick_t r);
    logic signed [127:0] e1h, e1v, e2h, e2v, det, mag, ph, pv, a, b, num, quo, d, best;
    e1h = t.v0h - t.v2h;
    e1v = t.v0v - t.v2v;
    e2h = t.v1h - t.v2h;
    e2v = t.v1v - t.v2v;
    det = e1h * e2v - e1v * e2h;
    mag = (det < 0) ? -det : det;
    if (det != 0 && !(mag < $signed({66'd0, min_area}))) begin
      ph = q_h - t.v2h - off_h;
      pv = q_v - t.v2v - off_v;
      a = ph * e2v - pv * e2h;
      b = e1h * pv - e1v * ph;
      if (det < 0) begin
        a = -a;
        b = -b;
      end
      if (a >= 0 && b >= 0 && a + b <= mag) begin
        num = (t.v0d - t.v2d) * a + (t.v1d - t.v2d) * b;
        quo = num / mag;
        // Division truncates; the block rounds toward minus infinity.
        if (num < 0 && num % mag != 0) quo = quo - 1;
        d = t.v2d + quo;
        if (d > 128'sd2147483647) d = 128'sd2147483647;
        if (d < -128'sd2147483648) d = -128'sd2147483648;
        best = mesh_best;
        if (!mesh_hit || best < d) mesh_best = d[CoordW-1:0];
        mesh_hit = 1'b1;
      end
    end
    r.hit = mesh_hit;
    r.depth = mesh_hit ? mesh_best : '0;
    if (t.last) begin
      mesh_hit = 1'b0;
      mesh_best = '0;
    end
    return t.last;
  endfunction

  function automatic void add_row(input tri_t t, input logic typed, input pick_t want);
    row_t row;
    row.t = t;
    row.typed = typed;
    row.want = want;
    steps.insert(steps.size(), row);
  endfunction

  // Result side: checks every popped transaction and idles in random bursts.
  int rx_idle = 0;
  int rx_hold = 0;
  logic rx_held = 1'b0;
  always @(posedge clk_i) begin
    pick_t e;
    if (rst_ni && pop && !empty) begin
      if (picks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b depth=%h", hit_o, depth_o);
      end else begin
        e = picks_due.pop_front();
        if (e.hit !== hit_o || e.depth !== depth_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b depth=%h, got hit=%0b depth=%h",
                     e.hit, e.depth, hit_o, depth_o);
        end
      end
    end
    if (hold_req && !rx_held) begin
      rx_held = 1'b1;
      rx_hold = 600;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle--;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_idle = $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_QUERY_H:  q_h = val[CoordW-1:0];
      REG_QUERY_V:  q_v = val[CoordW-1:0];
      REG_OFFSET_H: off_h = val[CoordW-1:0];
      REG_OFFSET_V: off_v = val[CoordW-1:0];
      REG_MIN_DET:  min_area = val[MinDetW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one triangle and waits for its transaction, then maybe idles.
  task automatic send_tri(input tri_t t, input logic typed, input pick_t want);
    pick_t r;
    drv <= t;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (pick_step(t, r)) picks_due.insert(picks_due.size(), typed ? want : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Triangles not flagged last give no result, so allow the back end to drain.
  task automatic drain;
    push <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic tri_t mk_tri(input int h0, v0, d0, h1, v1, d1, h2, v2, d2,
                                  input logic last);
    tri_t t;
    t = '{h0, v0, d0, h1, v1, d1, h2, v2, d2, last};
    return t;
  endfunction

  function automatic int jitter(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic tri_t rand_tri(input logic last);
    tri_t t;
    int span, ch, cv;
    if ($urandom_range(0, 5) == 0) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, last};
      return t;
    end
    span = 1 << $urandom_range(2, 24);
    ch = q_h - off_h + jitter(span / 2);
    cv = q_v - off_v + jitter(span / 2);
    t.v0h = ch + jitter(span); t.v0v = cv + jitter(span);
    t.v1h = ch + jitter(span); t.v1v = cv + jitter(span);
    t.v2h = ch + jitter(span); t.v2v = cv + jitter(span);
    if ($urandom_range(0, 3) == 0) begin
      t.v0d = $urandom; t.v1d = $urandom; t.v2d = $urandom;
    end else begin
      t.v0d = jitter(1 << 20); t.v1d = jitter(1 << 20); t.v2d = jitter(1 << 20);
    end
    // Collapsed triangles exercise the zero-determinant skip.
    if ($urandom_range(0, 15) == 0) begin
      t.v1h = t.v0h;
      t.v1v = t.v0v;
    end
    t.last = last;
    return t;
  endfunction

  initial begin
    logic [CfgDataW-1:0] phase_cfg[4][5];
    int mesh_left;
    int items;
    pick_t none;
    none = '0;

    // Directed rows, run with the reset configuration.
    add_row(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, {1'b0, 32'sd0});
    add_row(mk_tri(-65536, -65536, 327680, 65536, -65536, 327680,
                   0, 65536, 327680, 1'b1), 1'b1, {1'b1, 32'sd327680});
    // Query sits on a vertex; a later miss keeps that hit.
    add_row(mk_tri(65536, 0, 0, 0, 65536, 0, 0, 0, 458752, 1'b0), 1'b0, none);
    add_row(mk_tri(655360, 655360, 9, 720896, 655360, 9, 655360, 720896, 9, 1'b1),
            1'b1, {1'b1, 32'sd458752});
    add_row(mk_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'h80000000, 1'b1), 1'b0, none);
    add_row(mk_tri(65536, -65536, 100000, -65536, -65536, -300000,
                   0, 65536, 7, 1'b1), 1'b0, none);
    add_row(mk_tri(-65536, -65536, 32'h80000000, 65536, -65536, 32'h80000000,
                   0, 65536, 32'h80000000, 1'b1), 1'b1, {1'b1, 32'h80000000});
    add_row(mk_tri(-65536, -65536, 32'h7fffffff, 65536, -65536, 32'h7fffffff,
                   0, 65536, 32'h7fffffff, 1'b0), 1'b0, none);
    add_row(mk_tri(-65536, -65536, 5, 65536, -65536, 5, 0, 65536, 5, 1'b1),
            1'b1, {1'b1, 32'h7fffffff});
    // Two hits at equal depth, then a lower hit in the same mesh.
    add_row(mk_tri(-65536, -65536, 196608, 65536, -65536, 196608,
                   0, 65536, 196608, 1'b0), 1'b0, none);
    add_row(mk_tri(-131072, -65536, 196608, 65536, -65536, 196608,
                   0, 131072, 196608, 1'b0), 1'b0, none);
    add_row(mk_tri(-65536, -65536, -5, 65536, -65536, -5, 0, 65536, -5, 1'b1),
            1'b1, {1'b1, 32'sd196608});
    // Query on an edge, with a depth gradient that rounds downward.
    add_row(mk_tri(-3, 0, -7, 3, 0, 2, 0, 5, -1, 1'b1), 1'b0, none);
    add_row(mk_tri(-3, -1, -7, 3, -2, 2, 1, 5, 4, 1'b1), 1'b0, none);

    phase_cfg[0] = '{62'h30000, 62'h3fffe0000, 62'h10000, 62'h8000, 62'd0};
    phase_cfg[1] = '{62'h7fffffff, 62'h80000000, 62'h80000000, 62'h7fffffff,
                     62'h3fffffffffffffff};
    phase_cfg[2] = '{62'h3ffff8000, 62'h18000, 62'h3fff00000, 62'h100000, 62'h100000000};
    phase_cfg[3] = '{CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                     CfgDataW'($urandom), CfgDataW'({$urandom_range(0, 255), 20'd0})};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) send_tri(steps[i].t, steps[i].typed, steps[i].want);

    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int r = 0; r < 5; r++) cfg_write(r[CfgIdxW-1:0], phase_cfg[ph][r]);
      cfg_write(CfgIdxW'(5 + ph % 3), CfgDataW'({$urandom, $urandom}));
      // With min_det cleared, a flat triangle must still be skipped.
      if (ph == 0) send_tri(mk_tri(5, 5, 1, 5, 5, 1, 9, 9, 1, 1'b1), 1'b1, none);
      mesh_left = 0;
      for (int k = 0; k < 100; k++) begin
        if (mesh_left == 0) mesh_left = $urandom_range(1, 6);
        mesh_left--;
        if (ph == 0 && k == 10) hold_req <= 1'b1;
        if (ph == 3 && k == 40) quiet <= 1'b1;
        send_tri(rand_tri(mesh_left == 0), 1'b0, none);
        items++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
